/* src/rational_arithmetic_unit_macros.svh */
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Assertion that is off while reset is asserted.
`define RAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that also holds during reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation, status and order codes, queue item and unit request types.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned MW = 32;  // magnitude width
  localparam int unsigned DW = 64;  // double width

  // operation codes
  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_DIV  = 3'd3;
  localparam logic [2:0] FUNC_CMP  = 3'd4;
  localparam logic [2:0] FUNC_NORM = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  // order codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // classified request, sign and magnitude form
  typedef struct packed {
    logic [2:0]    func;
    logic [1:0]    status;
    logic          use_b;
    logic          a_neg;
    logic          b_neg;
    logic [MW-1:0] a_mag;
    logic [MW-1:0] a_den;
    logic [MW-1:0] b_mag;
    logic [MW-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] u;
    logic [DW-1:0] v;
  } gcd_req_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] value;
  } unit_rsp_t;

endpackage

`default_nettype wire

/* src/rau_if.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  func;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic        [30:0] res_den;
  logic        [1:0]  order;
  logic        [1:0]  status;

  modport source (output valid, res_num, res_den, order, status, input ready);
  modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

`default_nettype wire

/* src/rau_front.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts requests, splits operands into sign and magnitude, flags zero
// denominators and holds classified requests in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_front #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rau_in_if.sink             req_i,
  output rau_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  wire logic          item_ready_i
);

  // sign extend the low WIDTH bits of a field
  function automatic logic [32:0] sext(input logic [31:0] f);
    logic [32:0] e;
    e = 33'($signed(f[WIDTH-1:0]));
    return e;
  endfunction

  function automatic logic [31:0] mag(input logic [32:0] e);
    logic [32:0] n;
    n = 33'd0 - e;
    return e[32] ? n[31:0] : e[31:0];
  endfunction

  logic [32:0]    an_e, ad_e, bn_e, bd_e;
  rau_pkg::item_t cls;

  // classify
  always_comb begin
    an_e = sext(req_i.a_num);
    ad_e = sext(req_i.a_den);
    bn_e = sext(req_i.b_num);
    bd_e = sext(req_i.b_den);
    cls.func  = req_i.func;
    cls.use_b = (req_i.func <= rau_pkg::FUNC_CMP);
    cls.a_neg = an_e[32] ^ ad_e[32];
    cls.b_neg = bn_e[32] ^ bd_e[32];
    cls.a_mag = mag(an_e);
    cls.a_den = mag(ad_e);
    cls.b_mag = mag(bn_e);
    cls.b_den = mag(bd_e);
    if (cls.a_den == '0 || (cls.use_b && cls.b_den == '0)) begin
      cls.status = rau_pkg::STAT_ZDEN;
    end else begin
      cls.status = rau_pkg::STAT_OK;
    end
  end

  // two-entry queue
  rau_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign req_i.ready  = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = req_i.valid && req_i.ready;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

endmodule

`default_nettype wire

/* src/rau_gcd.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit gcd engine
// Binary gcd over double-width values, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rau_pkg::gcd_req_t  req_i,
  output rau_pkg::unit_rsp_t rsp_o
);

  localparam int unsigned DW = rau_pkg::DW;

  logic [DW-1:0]         u_q, v_q, g_q;
  logic [$clog2(DW)-1:0] k_q;
  logic                  busy_q, done_q;

  assign rsp_o.done  = done_q;
  assign rsp_o.value = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      u_q    <= '0;
      v_q    <= '0;
      k_q    <= '0;
      g_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        u_q    <= req_i.u;
        v_q    <= req_i.v;
        k_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (u_q == '0) begin
          g_q    <= v_q << k_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/rau_div.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rau_pkg::div_req_t  req_i,
  output rau_pkg::unit_rsp_t rsp_o
);

  localparam int unsigned DW = rau_pkg::DW;
  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign rsp_o.done  = done_q;
  assign rsp_o.value = quo_q;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/rau_back.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Sequencer that reduces operands, forms products and sums, compares,
// checks the result range and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_back #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  rau_pkg::item_t item_i,
  input  wire logic      item_valid_i,
  output logic           item_ready_o,
  rau_out_if.source      rsp_o
);

  localparam int unsigned DW = rau_pkg::DW;
  localparam int unsigned MW = rau_pkg::MW;
  localparam logic [DW-1:0] LIM_M1 = DW'((64'd1 << (WIDTH - 1)) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED_GW, S_RED_D1W, S_RED_D2W, S_RET,
    S_MUL1, S_MUL2, S_MUL3, S_COMB, S_CMP, S_FIT, S_FIN
  } state_e;

  typedef enum logic [1:0] {PH_A, PH_B, PH_L, PH_R} phase_e;

  state_e        st_q;
  phase_e        ph_q;
  logic [2:0]    func_q;
  logic          use_b_q, a_neg_q, b_neg_q, r_neg_q;
  logic [MW-1:0] a_mag_q, a_den_q, b_mag_q, b_den_q;
  logic [DW-1:0] x_q, y_q, g_q, l_q;
  logic [1:0]    status_q, order_q;
  logic [31:0]   res_num_q;
  logic [30:0]   res_den_q;
  logic          gcd_start_q, div_start_q;
  logic          rsp_valid_q;
  logic signed [31:0] rsp_num_q;
  logic [30:0]   rsp_den_q;
  logic [1:0]    rsp_order_q, rsp_status_q;

  rau_pkg::gcd_req_t  gcd_req;
  rau_pkg::div_req_t  div_req;
  rau_pkg::unit_rsp_t gcd_rsp, div_rsp;

  assign gcd_req = '{start: gcd_start_q, u: x_q, v: y_q};
  assign div_req = '{start: div_start_q, num: (st_q == S_RED_D2W) ? y_q : x_q, den: g_q};

  rau_gcd u_gcd (.clk_i, .rst_ni, .req_i(gcd_req), .rsp_o(gcd_rsp));
  rau_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // shared multiplier operand select
  logic          add_like;
  logic [MW-1:0] mul_a, mul_b;
  logic [DW-1:0] prod;

  assign add_like = (func_q == rau_pkg::FUNC_ADD) || (func_q == rau_pkg::FUNC_SUB);

  always_comb begin
    case (st_q)
      S_MUL1: begin
        mul_a = a_mag_q;
        if (func_q == rau_pkg::FUNC_MUL) mul_b = b_mag_q;
        else if (add_like)                mul_b = y_q[MW-1:0];
        else                              mul_b = b_den_q;
      end
      S_MUL2: begin
        mul_a = a_den_q;
        mul_b = (func_q == rau_pkg::FUNC_MUL || add_like) ? b_den_q : b_mag_q;
      end
      default: begin
        mul_a = b_mag_q;
        mul_b = a_den_q;
      end
    endcase
  end

  assign prod = {{(DW-MW){1'b0}}, mul_a} * {{(DW-MW){1'b0}}, mul_b};

  // signed combine of the cross products
  logic [DW-1:0] sum_mag;
  logic          sum_neg;

  always_comb begin
    if (a_neg_q == b_neg_q) begin
      sum_mag = x_q + y_q;
      sum_neg = a_neg_q;
    end else if (x_q >= y_q) begin
      sum_mag = x_q - y_q;
      sum_neg = a_neg_q;
    end else begin
      sum_mag = y_q - x_q;
      sum_neg = b_neg_q;
    end
  end

  // range check of the reduced result
  logic          fin_neg, fits;
  logic [DW-1:0] neg_x;

  assign fin_neg = r_neg_q && (x_q != '0);
  assign neg_x   = '0 - x_q;
  assign fits    = (y_q <= LIM_M1) && (fin_neg ? (x_q <= LIM_M1 + 1'b1) : (x_q <= LIM_M1));

  assign item_ready_o   = (st_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.res_num  = rsp_num_q;
  assign rsp_o.res_den  = rsp_den_q;
  assign rsp_o.order    = rsp_order_q;
  assign rsp_o.status   = rsp_status_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      ph_q         <= PH_A;
      gcd_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      rsp_valid_q  <= 1'b0;
      func_q       <= '0;
      use_b_q      <= 1'b0;
      a_neg_q      <= 1'b0;
      b_neg_q      <= 1'b0;
      r_neg_q      <= 1'b0;
      a_mag_q      <= '0;
      a_den_q      <= '0;
      b_mag_q      <= '0;
      b_den_q      <= '0;
      x_q          <= '0;
      y_q          <= '0;
      g_q          <= '0;
      l_q          <= '0;
      status_q     <= rau_pkg::STAT_OK;
      order_q      <= rau_pkg::ORD_LT;
      res_num_q    <= '0;
      res_den_q    <= '0;
      rsp_num_q    <= '0;
      rsp_den_q    <= '0;
      rsp_order_q  <= rau_pkg::ORD_LT;
      rsp_status_q <= rau_pkg::STAT_OK;
    end else begin
      gcd_start_q <= 1'b0;
      div_start_q <= 1'b0;
      // response taken; in S_FIN the next one is loaded instead
      if (rsp_valid_q && rsp_o.ready && st_q != S_FIN) rsp_valid_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (item_valid_i) begin
            func_q    <= item_i.func;
            use_b_q   <= item_i.use_b;
            a_neg_q   <= item_i.a_neg;
            b_neg_q   <= item_i.b_neg;
            a_mag_q   <= item_i.a_mag;
            a_den_q   <= item_i.a_den;
            b_mag_q   <= item_i.b_mag;
            b_den_q   <= item_i.b_den;
            status_q  <= item_i.status;
            order_q   <= rau_pkg::ORD_LT;
            res_num_q <= '0;
            res_den_q <= '0;
            x_q       <= DW'(item_i.a_mag);
            y_q       <= DW'(item_i.a_den);
            ph_q      <= PH_A;
            if (item_i.status != rau_pkg::STAT_OK) begin
              st_q <= S_FIN;
            end else begin
              gcd_start_q <= 1'b1;
              st_q        <= S_RED_GW;
            end
          end
        end
        // reduce x/y by their gcd
        S_RED_GW: begin
          if (gcd_rsp.done) begin
            g_q         <= gcd_rsp.value;
            div_start_q <= 1'b1;
            st_q        <= S_RED_D1W;
          end
        end
        S_RED_D1W: begin
          if (div_rsp.done) begin
            x_q         <= div_rsp.value;
            div_start_q <= 1'b1;
            st_q        <= S_RED_D2W;
          end
        end
        S_RED_D2W: begin
          if (div_rsp.done) begin
            y_q  <= div_rsp.value;
            st_q <= S_RET;
          end
        end
        // continue after a reduction
        S_RET: begin
          case (ph_q)
            PH_A: begin
              a_mag_q <= x_q[MW-1:0];
              a_den_q <= y_q[MW-1:0];
              a_neg_q <= a_neg_q && (x_q != '0);
              if (use_b_q) begin
                x_q         <= DW'(b_mag_q);
                y_q         <= DW'(b_den_q);
                ph_q        <= PH_B;
                gcd_start_q <= 1'b1;
                st_q        <= S_RED_GW;
              end else begin
                r_neg_q <= a_neg_q;
                st_q    <= S_FIT;
              end
            end
            PH_B: begin
              b_mag_q <= x_q[MW-1:0];
              b_den_q <= y_q[MW-1:0];
              b_neg_q <= (b_neg_q ^ (func_q == rau_pkg::FUNC_SUB)) && (x_q != '0);
              if (add_like) begin
                x_q         <= DW'(a_den_q);
                ph_q        <= PH_L;
                gcd_start_q <= 1'b1;
                st_q        <= S_RED_GW;
              end else if (func_q == rau_pkg::FUNC_DIV && x_q == '0) begin
                status_q <= rau_pkg::STAT_DIVZ;
                st_q     <= S_FIN;
              end else begin
                st_q <= S_MUL1;
              end
            end
            PH_L: begin
              a_den_q <= x_q[MW-1:0];
              st_q    <= S_MUL1;
            end
            default: st_q <= S_FIT;
          endcase
        end
        S_MUL1: begin
          x_q     <= prod;
          r_neg_q <= a_neg_q ^ b_neg_q;
          st_q    <= S_MUL2;
        end
        S_MUL2: begin
          if (add_like) begin
            l_q  <= prod;
            st_q <= S_MUL3;
          end else begin
            y_q <= prod;
            if (func_q == rau_pkg::FUNC_CMP) begin
              st_q <= S_CMP;
            end else begin
              ph_q        <= PH_R;
              gcd_start_q <= 1'b1;
              st_q        <= S_RED_GW;
            end
          end
        end
        S_MUL3: begin
          y_q  <= prod;
          st_q <= S_COMB;
        end
        S_COMB: begin
          x_q         <= sum_mag;
          y_q         <= l_q;
          r_neg_q     <= sum_neg;
          ph_q        <= PH_R;
          gcd_start_q <= 1'b1;
          st_q        <= S_RED_GW;
        end
        // cross products: x = |a|*den(b), y = |b|*den(a)
        S_CMP: begin
          if (a_neg_q != b_neg_q) begin
            order_q <= a_neg_q ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
          end else if (x_q == y_q) begin
            order_q <= rau_pkg::ORD_EQ;
          end else begin
            order_q <= ((x_q > y_q) != a_neg_q) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;
          end
          st_q <= S_FIN;
        end
        S_FIT: begin
          if (fits) begin
            res_num_q <= fin_neg ? neg_x[31:0] : x_q[31:0];
            res_den_q <= y_q[30:0];
          end else begin
            status_q <= rau_pkg::STAT_OVF;
          end
          st_q <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            if (status_q == rau_pkg::STAT_OK) begin
              rsp_num_q   <= res_num_q;
              rsp_den_q   <= res_den_q;
              rsp_order_q <= (func_q == rau_pkg::FUNC_CMP) ? order_q : rau_pkg::ORD_LT;
            end else begin
              rsp_num_q   <= '0;
              rsp_den_q   <= '0;
              rsp_order_q <= rau_pkg::ORD_LT;
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide, compare or normalize signed fractions,
// with results reduced by their greatest common divisor.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              handshake
//  req_i    in   func, a_num, a_den, b_num, b_den     valid/ready
//  rsp_o    out  res_num, res_den, order, status      valid/ready
//
//  A zero-denominator request goes from idle straight to the response
//  state; others run up to four reductions (a, b, the denominator gcd for
//  add and subtract, the result), each a binary gcd (one shift or subtract
//  per cycle) and two 64-step radix-2 divisions, plus the multiplier states
//  S_MUL1 to S_MUL3. Reset is asynchronous, active low; no clearing pass.
//  A two-entry queue takes requests while the sequencer works; a waiting
//  response is held in its register and the sequencer waits to finish.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    req_i,
  rau_out_if.source rsp_o
);

  rau_pkg::item_t item;
  logic           item_valid, item_ready;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .req_i,
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk_i,
    .rst_ni,
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .rsp_o
  );

endmodule

`default_nettype wire

/* src/rau_checker.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit port checker
// Response channel properties seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [31:0] res_num_i,
  input wire logic [30:0] res_den_i,
  input wire logic [1:0]  order_i,
  input wire logic [1:0]  status_i
);

  `RAU_ASSERT_ALWAYS(a_rst_no_valid, clk_i, !rst_ni |-> !valid_i, "response valid in reset")
  `RAU_ASSERT(a_hold, clk_i, rst_ni, valid_i && !ready_i |=> valid_i && $stable(res_num_i), "stalled response changed")
  `RAU_ASSERT(a_err_zero, clk_i, rst_ni, valid_i && status_i != rau_pkg::STAT_OK |-> res_num_i == '0 && res_den_i == '0 && order_i == rau_pkg::ORD_LT, "error response not cleared")
  `RAU_ASSERT(a_order_ok, clk_i, rst_ni, valid_i && order_i != rau_pkg::ORD_LT |-> status_i == rau_pkg::STAT_OK && order_i != 2'd3, "order without ok status")
  `RAU_ASSERT(a_den_set, clk_i, rst_ni, valid_i |-> res_den_i != '0 || res_num_i == '0, "nonzero numerator over zero denominator")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (rsp_o.valid),
  .ready_i   (rsp_o.ready),
  .res_num_i (rsp_o.res_num),
  .res_den_i (rsp_o.res_den),
  .order_i   (rsp_o.order),
  .status_i  (rsp_o.status)
);

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives add, subtract, multiply, divide, compare and normalize requests
// through random idle and stall phases and checks every response against an
// in-bench fraction predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } op_t;

  typedef struct {
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic        [1:0]  order;
    logic        [1:0]  status;
  } answer_t;

  // sign and magnitude fraction at double width
  typedef struct {
    bit        neg;
    bit [63:0] mag;
    bit [63:0] den;
  } ratio_t;

  logic clk_i;
  logic rst_ni;

  rau_in_if  req_if ();
  rau_out_if rsp_if ();

  rational_arithmetic_unit #(.WIDTH(32)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      hold_on;
  int      hold_cnt;
  int      n_fail;
  int      n_checked;
  int      n_status[4];

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic ratio_t reduce_ratio(ratio_t f);
    bit [63:0] g;
    g = gcd64(f.mag, f.den);
    if (g != 0) begin
      f.mag = f.mag / g;
      f.den = f.den / g;
    end
    if (f.mag == 0) begin
      f.neg = 1'b0;
      f.den = 1;
    end
    return f;
  endfunction

  function automatic ratio_t to_ratio(logic signed [31:0] n, logic signed [31:0] d);
    ratio_t    f;
    bit [63:0] n64;
    bit [63:0] d64;
    n64 = 64'(signed'(n));
    d64 = 64'(signed'(d));
    f.mag = n[31] ? -n64 : n64;
    f.den = d[31] ? -d64 : d64;
    f.neg = n[31] != d[31];
    return reduce_ratio(f);
  endfunction

  function automatic ratio_t ratio_sum(ratio_t x, ratio_t y);
    ratio_t    r;
    bit [63:0] l;
    bit [63:0] p;
    bit [63:0] q;
    l = (x.den / gcd64(x.den, y.den)) * y.den;
    p = x.mag * (l / x.den);
    q = y.mag * (l / y.den);
    r.den = l;
    if (x.neg == y.neg) begin
      r.mag = p + q;
      r.neg = x.neg;
    end else if (p >= q) begin
      r.mag = p - q;
      r.neg = x.neg;
    end else begin
      r.mag = q - p;
      r.neg = y.neg;
    end
    return reduce_ratio(r);
  endfunction

  function automatic ratio_t ratio_product(ratio_t x, ratio_t y);
    ratio_t r;
    r.mag = x.mag * y.mag;
    r.den = x.den * y.den;
    r.neg = x.neg != y.neg;
    return reduce_ratio(r);
  endfunction

  function automatic answer_t predict_answer(op_t op);
    answer_t   ans;
    ratio_t    a;
    ratio_t    b;
    ratio_t    r;
    ratio_t    inv;
    bit        use_b;
    bit        have_r;
    bit [1:0]  stat;
    bit [1:0]  ord;
    bit [63:0] p;
    bit [63:0] q;
    bit [63:0] lim;
    bit [63:0] n;
    use_b  = op.func <= FUNC_CMP;
    have_r = 1'b0;
    stat   = STAT_OK;
    ord    = ORD_LT;
    lim    = 64'd1 << 31;
    if (op.a_den == 0 || (use_b && op.b_den == 0)) begin
      stat = STAT_ZDEN;
    end else begin
      a = to_ratio(op.a_num, op.a_den);
      b = use_b ? to_ratio(op.b_num, op.b_den) : a;
      case (op.func)
        FUNC_ADD: begin
          r = ratio_sum(a, b); have_r = 1'b1;
        end
        FUNC_SUB: begin
          if (b.mag != 0) b.neg = !b.neg;
          r = ratio_sum(a, b); have_r = 1'b1;
        end
        FUNC_MUL: begin
          r = ratio_product(a, b); have_r = 1'b1;
        end
        FUNC_DIV: begin
          if (b.mag == 0) begin
            stat = STAT_DIVZ;
          end else begin
            inv.neg = b.neg; inv.mag = b.den; inv.den = b.mag;
            r = ratio_product(a, inv); have_r = 1'b1;
          end
        end
        FUNC_CMP: begin
          p = a.mag * b.den;
          q = b.mag * a.den;
          if (a.neg != b.neg) ord = a.neg ? ORD_LT : ORD_GT;
          else if (p == q)    ord = ORD_EQ;
          else                ord = ((p > q) != a.neg) ? ORD_GT : ORD_LT;
        end
        default: begin
          r = a; have_r = 1'b1;
        end
      endcase
    end
    // result must fit the operand width
    if (have_r && !(r.den <= lim - 1 && (r.neg ? r.mag <= lim : r.mag <= lim - 1))) begin
      stat   = STAT_OVF;
      have_r = 1'b0;
    end
    if (have_r) begin
      n = r.neg ? -r.mag : r.mag;
      ans.res_num = n[31:0];
      ans.res_den = r.den[30:0];
    end else begin
      ans.res_num = '0;
      ans.res_den = '0;
    end
    ans.order  = (stat == STAT_OK && op.func == FUNC_CMP) ? ord : ORD_LT;
    ans.status = stat;
    return ans;
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    op_t cur;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_ADD;
      req_if.a_num <= '0;
      req_if.a_den <= '0;
      req_if.b_num <= '0;
      req_if.b_den <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.func  = req_if.func;
        cur.a_num = req_if.a_num;
        cur.a_den = req_if.a_den;
        cur.b_num = req_if.b_num;
        cur.b_den = req_if.b_den;
        expected_answers.push_back(predict_answer(cur));
      end
      // offer the next request unless one is still waiting
      if (!(req_if.valid && !req_if.ready)) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur = pending_ops.pop_front();
          req_if.valid <= 1'b1;
          req_if.func  <= cur.func;
          req_if.a_num <= cur.a_num;
          req_if.a_den <= cur.a_den;
          req_if.b_num <= cur.b_num;
          req_if.b_den <= cur.b_den;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_answers.size() == 0) begin
          $error("response with no request outstanding");
          n_fail++;
        end else begin
          exp_a = expected_answers.pop_front();
          n_checked++;
          n_status[exp_a.status]++;
          if (rsp_if.res_num !== exp_a.res_num) begin
            $error("res_num: expected %0d, got %0d", exp_a.res_num, rsp_if.res_num);
            n_fail++;
          end
          if (rsp_if.res_den !== exp_a.res_den) begin
            $error("res_den: expected %0d, got %0d", exp_a.res_den, rsp_if.res_den);
            n_fail++;
          end
          if (rsp_if.order !== exp_a.order) begin
            $error("order: expected %0d, got %0d", exp_a.order, rsp_if.order);
            n_fail++;
          end
          if (rsp_if.status !== exp_a.status) begin
            $error("status: expected %0d, got %0d", exp_a.status, rsp_if.status);
            n_fail++;
          end
        end
      end
      // long hold-off so the input queue fills up
      if (hold_on && hold_cnt < 4000) begin
        hold_cnt     <= hold_cnt + 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_op(logic [2:0] f, int an, int ad, int bn, int bd);
    op_t op;
    op.func = f; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
      4, 5:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      6, 7:       return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default:    return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
    endcase
  endfunction

  task automatic add_random_ops(int count);
    repeat (count) begin
      add_op(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
             rand_operand(), rand_operand());
    end
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !req_if.valid && expected_answers.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_on        = 1'b0;
    n_fail         = 0;
    n_checked      = 0;
    n_status       = '{default: 0};
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every operation, errors and extremes
    add_op(FUNC_ADD,  1, 2, 1, 3);
    add_op(FUNC_SUB,  1, 2, 1, 2);
    add_op(FUNC_MUL, -3, 4, 8, -9);
    add_op(FUNC_DIV,  2, 3, -4, 5);
    add_op(FUNC_CMP,  1, 3, 2, 6);
    add_op(FUNC_CMP, -1, 3, 1, -2);
    add_op(FUNC_CMP,  5, 7, 2, 3);
    add_op(FUNC_NORM, 6, -8, 0, 0);
    add_op(FUNC_ADD,  1, 0, 1, 1);
    add_op(FUNC_ADD,  1, 1, 1, 0);
    add_op(FUNC_DIV,  1, 0, 0, 1);
    add_op(FUNC_DIV,  3, 5, 0, -7);
    add_op(FUNC_NORM, 0, -5, 3, 0);
    add_op(3'd6,     -4, 6, 1, 1);
    add_op(3'd7,      9, -3, 1, 0);
    add_op(FUNC_NORM, 32'h8000_0000, 1, 0, 1);
    add_op(FUNC_NORM, 1, 32'h8000_0000, 0, 1);
    add_op(FUNC_NORM, 32'h8000_0000, -1, 0, 1);
    add_op(FUNC_ADD,  32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    add_op(FUNC_SUB,  32'h8000_0000, 1, 1, 1);
    add_op(FUNC_MUL,  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffd);
    add_op(FUNC_DIV,  1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_op(FUNC_CMP,  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_op(FUNC_ADD,  0, -7, 0, 3);
    add_op(FUNC_ADD,  1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    add_random_ops(250);
    drain();

    send_idle_pct = 52; recv_stall_pct = 0;
    add_random_ops(250);
    drain();

    send_idle_pct = 0; recv_stall_pct = 52;
    add_random_ops(250);
    drain();

    send_idle_pct = 20; recv_stall_pct = 20;
    add_random_ops(250);
    drain();

    // receiver holds off while requests keep coming
    send_idle_pct = 0; recv_stall_pct = 10;
    hold_on = 1'b1;
    add_random_ops(325);
    drain();

    repeat (100) @(posedge clk_i);
    $display("checked %0d responses: %0d ok, %0d zero denominator, %0d divide by zero,",
             n_checked, n_status[STAT_OK], n_status[STAT_ZDEN], n_status[STAT_DIVZ]);
    $display("%0d overflow, across idle, stall and long hold-off phases", n_status[STAT_OVF]);
    if (n_fail == 0) begin
      $display("rational_arithmetic_unit test passed");
    end else begin
      $display("rational_arithmetic_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #300_000_000;
    $display("rational_arithmetic_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
